// ===== rtl/core/odpq_pkg.sv =====
// ----------------------------------------------------------------------------
// odpq_pkg
// Shared types, constants and helper functions for the ordered dither
// palette quantizer.
// ----------------------------------------------------------------------------
package odpq_pkg;

    // palette geometry
    localparam int PALETTE_SIZE = 8;
    localparam int PAIR_COUNT   = PALETTE_SIZE / 2;
    localparam int IDX_W        = 3;
    localparam int DIST_W       = 18;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;

    // largest squared distance, 3 * 255 * 255
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 * 255);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_EN = 3'd5;

    // all four palette pairs, pair k holds entries 2k and 2k+1
    typedef logic [PAIR_COUNT-1:0][CFG_DATA_W-1:0] t_pal;

    // one search candidate
    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] dsq;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    // floor(M/32) of the 4x4 bayer matrix, row-major by phase
    function automatic logic signed [3:0] dither_ofs(input logic [1:0] row,
                                                     input logic [1:0] col);
        logic signed [3:0] ofs;
        ofs = 4'sd0;
        case ({row, col})
            4'd0:    ofs = -4'sd4;
            4'd1:    ofs = 4'sd0;
            4'd2:    ofs = -4'sd3;
            4'd3:    ofs = 4'sd1;
            4'd4:    ofs = 4'sd2;
            4'd5:    ofs = -4'sd2;
            4'd6:    ofs = 4'sd3;
            4'd7:    ofs = -4'sd1;
            4'd8:    ofs = -4'sd2;
            4'd9:    ofs = 4'sd2;
            4'd10:   ofs = -4'sd3;
            4'd11:   ofs = 4'sd1;
            4'd12:   ofs = 4'sd4;
            4'd13:   ofs = 4'sd0;
            4'd14:   ofs = 4'sd3;
            4'd15:   ofs = -4'sd1;
            default: ofs = 4'sd0;
        endcase
        return ofs;
    endfunction

    // channel plus offset, clamped to 0..255
    function automatic logic [7:0] add_clamp(input logic [7:0] chan,
                                             input logic signed [3:0] ofs);
        logic signed [9:0] sum;
        logic [7:0]        res;
        sum = $signed({2'b00, chan}) + 10'(ofs);
        if (sum < 0) begin
            res = 8'd0;
        end else if (sum > 10'sd255) begin
            res = 8'd255;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

    // 24-bit rgb of one palette entry
    function automatic logic [23:0] entry_rgb(input t_pal pal,
                                              input logic [IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] pair;
        pair = pal[idx[IDX_W-1:1]];
        return idx[0] ? pair[47:24] : pair[23:0];
    endfunction

    // keep a (lower index) unless b is valid and a is not, or b is strictly nearer
    function automatic t_cand pick(input t_cand a, input t_cand b);
        return (b.ok && (!a.ok || b.dsq < a.dsq)) ? b : a;
    endfunction

endpackage

// ===== rtl/core/ordered_dither_palette_quantizer_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_palette_quantizer_unit
// Ordered 4x4 bayer dither followed by a nearest-color search over an
// eight-entry rgb palette.
// ----------------------------------------------------------------------------
// Five-stage pipeline: one request enters per clock unless the output stalls,
// so the sustained rate is one pixel per clock. Stage 1 applies the dither
// offset and clamp, stage 2 squares the per-channel differences against all
// eight entries, stage 3 sums them, stages 4 and 5 run the lowest-index-wins
// compare tree and form the output word. A stall on the output freezes the
// whole pipeline; bubbles are not squeezed out. The palette, count and dither
// enable must only be rewritten while the pipeline is empty.
module ordered_dither_palette_quantizer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [odpq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odpq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input requests
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [31:0]                    i_pixel_in,
    input  logic [1:0]                     i_col_phase,
    input  logic [1:0]                     i_row_phase,
    // result requests
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_pixel_out,
    output logic [odpq_pkg::IDX_W-1:0]     o_palette_index
);
    import odpq_pkg::*;

    // configuration registers
    t_pal        r_pal;
    logic [3:0]  r_count;
    logic        r_dith_en;

    // pipeline valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic n_adv;

    // stage payloads
    logic [7:0]  r_s1_r, r_s1_g, r_s1_b;
    logic        r_s1_zero;
    logic [PALETTE_SIZE-1:0][2:0][15:0] r_s2_sq;
    logic        r_s2_zero;
    t_cand [PALETTE_SIZE-1:0] r_s3_cand;
    logic        r_s3_zero;
    t_cand [PALETTE_SIZE/2-1:0] r_s4_cand;
    logic        r_s4_zero;
    logic [31:0]      r_pixel_out;
    logic [IDX_W-1:0] r_index;

    // combinational next values
    logic signed [3:0] n_ofs;
    logic [7:0]        n_r, n_g, n_b;
    logic [PALETTE_SIZE-1:0][2:0][15:0] n_sq;
    logic [3:0]        n_lim;
    t_cand [PALETTE_SIZE-1:0]   n_cand;
    t_cand [PALETTE_SIZE/2-1:0] n_half;
    t_cand             n_best;
    logic [23:0]       n_rgb;

    // pipeline moves whenever the output register is free or being taken
    assign n_adv       = !r_v5 || i_out_ready;
    assign o_in_ready  = n_adv;
    assign o_out_valid = r_v5;
    assign o_pixel_out = r_pixel_out;
    assign o_palette_index = r_index;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal     <= '0;
            r_count   <= 4'd1;
            r_dith_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAIR_0:    r_pal[0] <= i_cfg_data;
                REG_PAIR_1:    r_pal[1] <= i_cfg_data;
                REG_PAIR_2:    r_pal[2] <= i_cfg_data;
                REG_PAIR_3:    r_pal[3] <= i_cfg_data;
                REG_COUNT:     r_count <= i_cfg_data[3:0];
                REG_DITHER_EN: r_dith_en <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (n_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: dither offset and clamp
    always_comb begin
        n_ofs = dither_ofs(i_row_phase, i_col_phase);
        if (r_dith_en) begin
            n_r = add_clamp(i_pixel_in[31:24], n_ofs);
            n_g = add_clamp(i_pixel_in[23:16], n_ofs);
            n_b = add_clamp(i_pixel_in[15:8], n_ofs);
        end else begin
            n_r = i_pixel_in[31:24];
            n_g = i_pixel_in[23:16];
            n_b = i_pixel_in[15:8];
        end
    end

    // stage 2: squared channel differences against every entry
    always_comb begin
        logic [23:0] c;
        logic [7:0]  dr, dg, db;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            c  = entry_rgb(r_pal, IDX_W'(i));
            dr = (c[23:16] > r_s1_r) ? c[23:16] - r_s1_r : r_s1_r - c[23:16];
            dg = (c[15:8] > r_s1_g) ? c[15:8] - r_s1_g : r_s1_g - c[15:8];
            db = (c[7:0] > r_s1_b) ? c[7:0] - r_s1_b : r_s1_b - c[7:0];
            n_sq[i][0] = 16'(dr) * 16'(dr);
            n_sq[i][1] = 16'(dg) * 16'(dg);
            n_sq[i][2] = 16'(db) * 16'(db);
        end
    end

    // stage 3: distance sums, in-range and below-bound check
    always_comb begin
        n_lim = (r_count > 4'(PALETTE_SIZE)) ? 4'(PALETTE_SIZE) : r_count;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            n_cand[i].dsq  = DIST_W'(r_s2_sq[i][0]) + DIST_W'(r_s2_sq[i][1])
                           + DIST_W'(r_s2_sq[i][2]);
            n_cand[i].idx  = IDX_W'(i);
            n_cand[i].ok   = (4'(i) < n_lim) && (n_cand[i].dsq < MAX_DIST);
        end
    end

    // stage 4: first tree level, eight to four
    always_comb begin
        for (int i = 0; i < PALETTE_SIZE / 2; i++) begin
            n_half[i] = pick(r_s3_cand[2*i], r_s3_cand[2*i+1]);
        end
    end

    // stage 5: last two levels and output word
    always_comb begin
        n_best = pick(pick(r_s4_cand[0], r_s4_cand[1]),
                      pick(r_s4_cand[2], r_s4_cand[3]));
        if (!n_best.ok) begin
            n_best.idx = '0;
        end
        n_rgb = entry_rgb(r_pal, n_best.idx);
    end

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_s1_r    <= n_r;
            r_s1_g    <= n_g;
            r_s1_b    <= n_b;
            r_s1_zero <= (i_pixel_in == 32'd0);
            r_s2_sq   <= n_sq;
            r_s2_zero <= r_s1_zero;
            r_s3_cand <= n_cand;
            r_s3_zero <= r_s2_zero;
            r_s4_cand <= n_half;
            r_s4_zero <= r_s3_zero;
            if (r_s4_zero) begin
                r_pixel_out <= 32'd0;
                r_index     <= '0;
            end else begin
                r_pixel_out <= {n_rgb, 8'hFF};
                r_index     <= n_best.idx;
            end
        end
    end

`ifndef ASSERT_OFF
    // a zero alpha only comes from a zero pixel, which maps to index 0
    a_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_pixel_out[7:0] != 8'hFF) |-> (r_pixel_out == 32'd0 && r_index == '0))
        else $error("zero pixel result malformed");

    // a chosen index lies within the palette count, else falls back to 0
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_pixel_out != 32'd0) |-> (r_index == '0 || {1'b0, r_index} < r_count))
        else $error("palette index beyond count");

    // a held result is not dropped while the output stalls
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !i_out_ready) |=> (r_v5 && $stable(r_pixel_out) && $stable(r_index)))
        else $error("stalled result changed");

    // the pipeline freezes as a whole under stall
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_adv |=> ($stable(r_v1) && $stable(r_v4) && $stable(r_s4_zero)))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered dither palette quantizer. A local
// predictor mirrors the dither, clamp and nearest-color search for every
// accepted pixel request. A checker process compares each result request,
// field by field, against the oldest pending prediction. Directed tests hit
// rails, ties, far pixels and count limits. Random tests vary the palette,
// the count, the dither enable and the handshake pressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    // run limits
    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 12;
    localparam int FAR_BOUND     = 3 * 255 * 255;
    localparam int RANDOM_BATCH  = 150;

    // indexes outside the register map, writes there are dropped
    localparam logic [odpq_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [odpq_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    // one quantized result
    typedef struct packed {
        logic [31:0] pix;
        logic [2:0]  idx;
    } t_quant;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [odpq_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [odpq_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [31:0]                      i_pixel_in;
    logic [1:0]                       i_col_phase;
    logic [1:0]                       i_row_phase;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [31:0]                      o_pixel_out;
    logic [odpq_pkg::IDX_W-1:0]       o_palette_index;

    // mirrored register state
    logic [47:0] pal_pair [0:3];
    logic [3:0]  pal_count;
    logic        dith_on;

    t_quant pending_quant [$];
    t_quant head_quant;
    int     error_count;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_left;

    ordered_dither_palette_quantizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_in      (i_pixel_in),
        .i_col_phase     (i_col_phase),
        .i_row_phase     (i_row_phase),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_out     (o_pixel_out),
        .o_palette_index (o_palette_index)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // rgb of one mirrored palette entry
    function automatic logic [23:0] palette_rgb(input logic [2:0] idx);
        logic [47:0] pair;
        pair = pal_pair[idx[2:1]];
        return idx[0] ? pair[47:24] : pair[23:0];
    endfunction

    function automatic int clamp_chan(input int v);
        if (v < 0) begin
            return 0;
        end else if (v > 255) begin
            return 255;
        end
        return v;
    endfunction

    // dither, clamp and nearest-color search for one pixel
    function automatic t_quant quantize_pixel(input logic [31:0] pix,
                                              input logic [1:0] col,
                                              input logic [1:0] row);
        t_quant      res;
        int          r, g, b, m, ofs, n, d, best_d, dr, dg, db;
        logic [2:0]  best;
        logic [23:0] rgb;
        res.pix = 32'd0;
        res.idx = 3'd0;
        if (pix == 32'd0) begin
            return res;
        end
        r = int'(pix[31:24]);
        g = int'(pix[23:16]);
        b = int'(pix[15:8]);
        if (dith_on) begin
            // bayer matrix by phase, the offset is its floor over 32
            case ({row, col})
                4'd0:    m = -112;
                4'd1:    m = 16;
                4'd2:    m = -80;
                4'd3:    m = 48;
                4'd4:    m = 80;
                4'd5:    m = -48;
                4'd6:    m = 112;
                4'd7:    m = -16;
                4'd8:    m = -64;
                4'd9:    m = 64;
                4'd10:   m = -96;
                4'd11:   m = 32;
                4'd12:   m = 128;
                4'd13:   m = 0;
                4'd14:   m = 96;
                default: m = -32;
            endcase
            ofs = m >>> 5;
            r = clamp_chan(r + ofs);
            g = clamp_chan(g + ofs);
            b = clamp_chan(b + ofs);
        end
        // count saturates at the palette size
        n = (pal_count > 4'd8) ? 8 : int'(pal_count);
        best = 3'd0;
        best_d = FAR_BOUND;
        for (int i = 0; i < n; i++) begin
            rgb = palette_rgb(3'(i));
            dr = int'(rgb[23:16]) - r;
            dg = int'(rgb[15:8]) - g;
            db = int'(rgb[7:0]) - b;
            d = dr * dr + dg * dg + db * db;
            if (d < best_d) begin
                best_d = d;
                best = 3'(i);
            end
        end
        res.pix = {palette_rgb(best), 8'hFF};
        res.idx = best;
        return res;
    endfunction

    // one of the channel rails
    function automatic logic [7:0] rail_byte();
        case ($urandom_range(3, 0))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFE;
            default: return 8'hFF;
        endcase
    endfunction

    // register write, mirrored into the predictor state
    task automatic write_reg(input logic [odpq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [odpq_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            odpq_pkg::REG_PAIR_0,
            odpq_pkg::REG_PAIR_1,
            odpq_pkg::REG_PAIR_2,
            odpq_pkg::REG_PAIR_3:    pal_pair[idx[1:0]] = data;
            odpq_pkg::REG_COUNT:     pal_count = data[3:0];
            odpq_pkg::REG_DITHER_EN: dith_on = data[0];
            default: ;
        endcase
    endtask

    task automatic release_cfg();
        i_cfg_we <= 1'b0;
    endtask

    // offer one pixel request and record its prediction on acceptance
    task automatic send_pixel(input logic [31:0] pix, input logic [1:0] col,
                              input logic [1:0] row);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= pix;
        i_col_phase <= col;
        i_row_phase <= row;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_quant.push_back(quantize_pixel(pix, col, row));
    endtask

    // stop offering and wait for every pending result
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_quant.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // random pixel: zero, rails, near a palette entry or anything
    task automatic send_random_pixel();
        logic [31:0] pix;
        logic [23:0] rgb;
        int          kind;
        kind = $urandom_range(15, 0);
        pix = $urandom();
        if (kind == 0) begin
            pix = 32'd0;
        end else if (kind == 1) begin
            pix[31:8] = {rail_byte(), rail_byte(), rail_byte()};
        end else if (kind < 8) begin
            rgb = palette_rgb(3'($urandom_range(7, 0)));
            pix[31:24] = rgb[23:16] + 8'($urandom_range(12, 0)) - 8'd6;
            pix[23:16] = rgb[15:8] + 8'($urandom_range(12, 0)) - 8'd6;
            pix[15:8] = rgb[7:0] + 8'($urandom_range(12, 0)) - 8'd6;
        end
        send_pixel(pix, 2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)));
    endtask

    // random palette with some rails and duplicates, random count and dither, sometimes a dropped write
    task automatic randomize_regs();
        logic [47:0] pair;
        for (int k = 0; k < 4; k++) begin
            pair = 48'({$urandom(), $urandom()});
            case ($urandom_range(7, 0))
                0: pair[23:0] = 24'h000000;
                1: pair[47:24] = 24'hFFFFFF;
                2: pair[47:24] = pair[23:0];
                default: ;
            endcase
            write_reg(odpq_pkg::REG_PAIR_0 + 3'(k), pair);
        end
        pair = 48'({$urandom(), $urandom()});
        if ($urandom_range(9, 0) < 7) begin
            pair[3:0] = 4'($urandom_range(8, 1));
        end
        write_reg(odpq_pkg::REG_COUNT, pair);
        write_reg(odpq_pkg::REG_DITHER_EN, 48'({$urandom(), $urandom()}));
        if ($urandom_range(3, 0) == 0) begin
            write_reg($urandom_range(1, 0) ? REG_UNUSED_6 : REG_UNUSED_7,
                      48'({$urandom(), $urandom()}));
        end
        release_cfg();
    endtask

    // defaults after reset: one black entry, dither on
    task automatic test_reset_defaults();
        send_pixel(32'h00000000, 2'd1, 2'd2);
        send_pixel(32'h000000FF, 2'd0, 2'd3);
        send_pixel(32'hFFFFFFFF, 2'd3, 2'd3);
        wait_results_drained();
    endtask

    // primary colors, rails and clamps on both sides, dither on and off
    task automatic test_palette_extremes();
        write_reg(odpq_pkg::REG_PAIR_0, {24'hFFFFFF, 24'h000000});
        write_reg(odpq_pkg::REG_PAIR_1, {24'h00FF00, 24'hFF0000});
        write_reg(odpq_pkg::REG_PAIR_2, {24'h808080, 24'h0000FF});
        write_reg(odpq_pkg::REG_PAIR_3, {24'h00FFFF, 24'hFFFF00});
        write_reg(odpq_pkg::REG_COUNT, 48'd8);
        write_reg(odpq_pkg::REG_DITHER_EN, 48'd1);
        release_cfg();
        send_pixel(32'hFFFFFFFF, 2'd0, 2'd0);
        send_pixel(32'hFFFFFF00, 2'd0, 2'd3);
        send_pixel(32'h01020300, 2'd0, 2'd0);
        send_pixel(32'h00000001, 2'd3, 2'd3);
        send_pixel(32'hFE0000AA, 2'd1, 2'd1);
        send_pixel(32'h0000FF00, 2'd2, 2'd2);
        send_pixel(32'h7F7F7F00, 2'd1, 2'd2);
        send_pixel(32'h8282827F, 2'd3, 2'd1);
        wait_results_drained();
        write_reg(odpq_pkg::REG_DITHER_EN, 48'd0);
        release_cfg();
        send_pixel(32'h7C7C7C00, 2'd0, 2'd0);
        send_pixel(32'h00000000, 2'd2, 2'd1);
        wait_results_drained();
    endtask

    // equal distances keep the lowest index, far pixels fall back to entry 0
    task automatic test_ties_and_far();
        for (int k = 0; k < 4; k++) begin
            write_reg(odpq_pkg::REG_PAIR_0 + 3'(k), {24'h404040, 24'h404040});
        end
        write_reg(odpq_pkg::REG_COUNT, 48'd8);
        write_reg(odpq_pkg::REG_DITHER_EN, 48'd0);
        release_cfg();
        send_pixel(32'h40404011, 2'd0, 2'd0);
        send_pixel(32'h10203000, 2'd2, 2'd1);
        wait_results_drained();
        // entries 1 and 2 sit at the same distance from the pixel
        write_reg(odpq_pkg::REG_PAIR_0, {24'h100000, 24'hFFFFFF});
        write_reg(odpq_pkg::REG_PAIR_1, {24'hFFFFFF, 24'h300000});
        write_reg(odpq_pkg::REG_PAIR_2, {24'hFFFFFF, 24'hFFFFFF});
        write_reg(odpq_pkg::REG_PAIR_3, {24'hFFFFFF, 24'hFFFFFF});
        release_cfg();
        send_pixel(32'h200000AB, 2'd1, 2'd3);
        wait_results_drained();
        // every entry exactly at the distance bound
        for (int k = 0; k < 4; k++) begin
            write_reg(odpq_pkg::REG_PAIR_0 + 3'(k), 48'd0);
        end
        release_cfg();
        send_pixel(32'hFFFFFF01, 2'd2, 2'd0);
        wait_results_drained();
        write_reg(odpq_pkg::REG_DITHER_EN, 48'd1);
        release_cfg();
        send_pixel(32'hFFFFFF01, 2'd0, 2'd3);
        wait_results_drained();
    endtask

    // count of zero, saturation above the size, partial count, dropped writes
    task automatic test_count_limits();
        write_reg(odpq_pkg::REG_PAIR_0, {24'h111111, 24'hABCDEF});
        write_reg(odpq_pkg::REG_PAIR_1, {24'h333333, 24'h222222});
        write_reg(odpq_pkg::REG_PAIR_2, {24'h555555, 24'h444444});
        write_reg(odpq_pkg::REG_PAIR_3, {24'hF0F0F0, 24'h666666});
        write_reg(odpq_pkg::REG_DITHER_EN, 48'd0);
        write_reg(odpq_pkg::REG_COUNT, 48'd0);
        release_cfg();
        send_pixel(32'hF0F0F000, 2'd0, 2'd0);
        wait_results_drained();
        write_reg(odpq_pkg::REG_COUNT, 48'd15);
        release_cfg();
        send_pixel(32'hF0F0F000, 2'd1, 2'd0);
        wait_results_drained();
        write_reg(odpq_pkg::REG_COUNT, 48'd9);
        release_cfg();
        send_pixel(32'hF0F0F0FF, 2'd2, 2'd1);
        wait_results_drained();
        write_reg(odpq_pkg::REG_COUNT, 48'd3);
        release_cfg();
        send_pixel(32'hF0F0F000, 2'd3, 2'd2);
        wait_results_drained();
        write_reg(REG_UNUSED_6, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_UNUSED_7, 48'hFFFF_FFFF_FFFF);
        release_cfg();
        send_pixel(32'hF0F0F000, 2'd3, 2'd3);
        wait_results_drained();
    endtask

    // random stream under three idle mixes, fresh registers per batch
    task automatic test_random_stream();
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int batch = 0; batch < 3; batch++) begin
                randomize_regs();
                for (int n = 0; n < RANDOM_BATCH; n++) begin
                    send_random_pixel();
                end
                wait_results_drained();
            end
        end
    endtask

    // long receiver hold-off while requests keep coming, pipeline fills up
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomize_regs();
        hold_left = 150;
        for (int n = 0; n < 40; n++) begin
            send_random_pixel();
        end
        wait_results_drained();
    endtask

    // receiver ready, random idling or a counted hold-off
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // compare each result request against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_quant.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %08h idx %0d",
                         $time, o_pixel_out, o_palette_index);
                error_count++;
            end else begin
                head_quant = pending_quant.pop_front();
                if (o_pixel_out !== head_quant.pix) begin
                    $display("%0t: pixel_out mismatch, expected %08h, actual %08h",
                             $time, head_quant.pix, o_pixel_out);
                    error_count++;
                end
                if (o_palette_index !== head_quant.idx) begin
                    $display("%0t: palette_index mismatch, expected %0d, actual %0d",
                             $time, head_quant.idx, o_palette_index);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        error_count = 0;
        hold_left = 0;
        send_idle_pct = 36;
        recv_idle_pct = 72;
        for (int k = 0; k < 4; k++) begin
            pal_pair[k] = 48'd0;
        end
        pal_count = 4'd1;
        dith_on = 1'b1;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= odpq_pkg::REG_PAIR_0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_pixel_in <= 32'd0;
        i_col_phase <= 2'd0;
        i_row_phase <= 2'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_palette_extremes();
        test_ties_and_far();
        test_count_limits();
        test_random_stream();
        test_output_stall();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
